### src/double_ended_queue_defines.svh
// Assertion macros for the double-ended queue.
// Needs signals named clock and reset in the including module.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Condition that must hold at every edge out of reset.
`define DQ_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define DQ_ASSERT_NEXT(label, trig, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (expr)) else $error(msg);

`endif

### src/dq_pkg.sv
// Shared types and constants for the double-ended queue.
// No dependencies.
package dq_pkg;

   localparam int DEPTH    = 16;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int DATA_W   = 32;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_PEEK       = 3'd4;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [DATA_W-1:0] push_data;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] popped_data;
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] front_data;
      logic signed [DATA_W-1:0] back_data;
      logic [COUNT_W-1:0]       count;
   } rsp_type;

endpackage

### src/dq_ram.sv
// Simple dual-port RAM, one write and one registered read port.
// No dependencies.
module dq_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### src/double_ended_queue.sv
// Double-ended queue of signed 32-bit words over a ring RAM.
// Depends on dq_pkg, dq_ram and double_ended_queue_defines.svh.
//
// Usage:
//   req_* carries one request: op (push front, push back, pop front,
//   pop back, peek) and push_data. rsp_* returns one response per request:
//   popped word, status (ok / empty / full), front and back words after the
//   request (zero when empty) and the stored word count.
// Timing:
//   One request is in flight at a time. The response is registered and shows
//   on rsp_valid once the request has passed through S_DONE into the response
//   register; a pop that leaves words behind first passes through S_READ, as
//   the new end word must be fetched from the ring RAM, whose read port is
//   registered. Front and back words are kept in registers, so pushes and
//   pops of the old end words need no RAM read.
// Reset:
//   Synchronous, active high. The deque comes up empty; the RAM contents are
//   not cleared, since no entry is read before it is written.
// Stall:
//   The response register holds until rsp_ready. A new request is taken as
//   soon as the previous one has moved into the response register, so one
//   request can be in work while the last response waits.
module double_ended_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  dq_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output dq_pkg::rsp_type rsp_data
);
   import dq_pkg::*;

   `include "double_ended_queue_defines.svh"

   typedef enum logic [1:0] {
      S_IDLE,   // waiting for a request
      S_READ,   // RAM read of the new end word in flight
      S_DONE    // response ready to move into the output register
   } state_type;

   // control state
   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] front_ff, front_in;
   logic [ADDR_W-1:0] back_ff, back_in;    // always front + count - 1, mod DEPTH
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [DATA_W-1:0] front_word_ff, front_word_in;
   logic [DATA_W-1:0] back_word_ff, back_word_in;
   logic [DATA_W-1:0] popped_ff, popped_in;
   status_type        status_ff, status_in;
   logic              read_front_ff, read_front_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // RAM port
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data, rd_data;

   logic              accept, is_empty, is_full;
   logic [ADDR_W-1:0] front_dec, front_inc, back_dec, back_inc;

   dq_ram #(
      .DATA_W (DATA_W),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CNT_W'(DEPTH));

   // ring pointer steps with wrap at DEPTH
   assign front_dec = (front_ff == '0) ? ADDR_W'(DEPTH - 1) : front_ff - ADDR_W'(1);
   assign front_inc = (front_ff == ADDR_W'(DEPTH - 1)) ? '0 : front_ff + ADDR_W'(1);
   assign back_dec  = (back_ff == '0) ? ADDR_W'(DEPTH - 1) : back_ff - ADDR_W'(1);
   assign back_inc  = (back_ff == ADDR_W'(DEPTH - 1)) ? '0 : back_ff + ADDR_W'(1);

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      count_in      = count_ff;
      front_word_in = front_word_ff;
      back_word_in  = back_word_ff;
      popped_in     = popped_ff;
      status_in     = status_ff;
      read_front_in = read_front_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      wr_en         = 1'b0;
      wr_addr       = front_dec;
      wr_data       = req_data.push_data;
      rd_en         = 1'b0;
      rd_addr       = front_inc;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               popped_in = '0;
               status_in = ST_OK;
               state_in  = S_DONE;
               case (req_data.op)
                  OP_PUSH_FRONT: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        front_in      = front_dec;
                        wr_en         = 1'b1;
                        wr_addr       = front_dec;
                        front_word_in = req_data.push_data;
                        if (is_empty) begin
                           back_word_in = req_data.push_data;
                        end
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        back_in      = back_inc;
                        wr_en        = 1'b1;
                        wr_addr      = back_inc;
                        back_word_in = req_data.push_data;
                        if (is_empty) begin
                           front_word_in = req_data.push_data;
                        end
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_POP_FRONT: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        popped_in = front_word_ff;
                        front_in  = front_inc;
                        count_in  = count_ff - CNT_W'(1);
                        // fetch the new front word unless the deque drains
                        if (count_ff != CNT_W'(1)) begin
                           rd_en         = 1'b1;
                           rd_addr       = front_inc;
                           read_front_in = 1'b1;
                           state_in      = S_READ;
                        end
                     end
                  end
                  OP_POP_BACK: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        popped_in = back_word_ff;
                        back_in   = back_dec;
                        count_in  = count_ff - CNT_W'(1);
                        if (count_ff != CNT_W'(1)) begin
                           rd_en         = 1'b1;
                           rd_addr       = back_dec;
                           read_front_in = 1'b0;
                           state_in      = S_READ;
                        end
                     end
                  end
                  OP_PEEK: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end
                  end
                  default: begin
                     // unused codes: no-op, status ok
                  end
               endcase
            end
         end
         S_READ: begin
            if (read_front_ff) begin
               front_word_in = rd_data;
            end else begin
               back_word_in = rd_data;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.popped_data = popped_ff;
               rsp_data_in.status      = status_ff;
               rsp_data_in.front_data  = is_empty ? '0 : front_word_ff;
               rsp_data_in.back_data   = is_empty ? '0 : back_word_ff;
               rsp_data_in.count       = COUNT_W'(count_ff);
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         back_ff      <= ADDR_W'(DEPTH - 1);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      front_word_ff <= front_word_in;
      back_word_ff  <= back_word_in;
      popped_ff     <= popped_in;
      status_ff     <= status_in;
      read_front_ff <= read_front_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // back pointer check: front + count - 1 + DEPTH lies below 3 * DEPTH
   localparam logic [ADDR_W+1:0] DEPTH_X = (ADDR_W+2)'(DEPTH);
   logic [ADDR_W+1:0] back_sum, back_ext;
   logic              back_ok;
   assign back_sum = (ADDR_W+2)'(front_ff) + (ADDR_W+2)'(count_ff)
                   + (ADDR_W+2)'(DEPTH - 1);
   assign back_ext = (ADDR_W+2)'(back_ff);
   assign back_ok  = (back_sum == back_ext) || (back_sum == back_ext + DEPTH_X)
                  || (back_sum == back_ext + DEPTH_X + DEPTH_X);

   `DQ_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(DEPTH), "count above depth")
   `DQ_ASSERT_ALWAYS(a_back_ptr, back_ok, "back pointer out of step")
   `DQ_ASSERT_NEXT(a_read_state, rd_en, state_ff == S_READ, "RAM read without read state")
   `DQ_ASSERT_NEXT(a_hold_ptrs, !accept, $stable(front_ff) && $stable(count_ff), "pointers moved without request")

endmodule

### verif/testbench.sv
// Self-checking testbench for double_ended_queue: drives request streams over
// the valid/ready ports, predicts every response with a deque mirror.
// Depends on dq_pkg and the double_ended_queue RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dq_pkg::*;

   // Run limits. The slowest legal run is about 1600 requests, each with the
   // longest sender gap, the longest receiver stall and the work of a pop that
   // reads the RAM. The limit allows several times that.
   localparam int CYCLE_LIMIT     = 600000;
   localparam int SETTLE_CYCLES   = 20;
   localparam int RANDOM_REQUESTS = 1300;
   localparam int HOLDOFF_CYCLES  = 200;

   // Op codes 5..7 have no defined meaning. The block must treat them as no-ops.
   localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Traffic controls, changed by the test tasks.
   bit          sender_idles    = 1'b1;
   bit          receiver_idles  = 1'b1;
   int unsigned holdoff_request = 0;

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   // Responses predicted for accepted requests, oldest first.
   rsp_type expected_rsps[$];

   // Mirror of the deque contents: ring, front slot and fill level.
   logic signed [DATA_W-1:0] mirror_words [DEPTH];
   int                       mirror_front = 0;
   int                       mirror_count = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   double_ended_queue DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // ---------------------------------------------------------------------
   // Deque predictor
   // ---------------------------------------------------------------------

   // Ring slot of the back word. Only meaningful while the deque holds words.
   function automatic int tail_index();
      return (mirror_front + mirror_count + DEPTH - 1) % DEPTH;
   endfunction

   // Apply one request to the mirror and return the response it must give.
   function automatic rsp_type apply_deque_op(input req_type item);
      rsp_type outcome;
      outcome        = '0;
      outcome.status = ST_OK;
      case (item.op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (mirror_count >= DEPTH) begin
               outcome.status = ST_FULL;      // refused, nothing moves
            end else if (item.op == OP_PUSH_FRONT) begin
               mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
               mirror_words[mirror_front] = item.push_data;
               mirror_count++;
            end else begin
               mirror_count++;
               mirror_words[tail_index()] = item.push_data;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (mirror_count == 0) begin
               outcome.status = ST_EMPTY;
            end else if (item.op == OP_POP_FRONT) begin
               outcome.popped_data = mirror_words[mirror_front];
               mirror_front = (mirror_front + 1) % DEPTH;
               mirror_count--;
            end else begin
               outcome.popped_data = mirror_words[tail_index()];
               mirror_count--;
            end
         end
         OP_PEEK: begin
            if (mirror_count == 0) begin
               outcome.status = ST_EMPTY;
            end
         end
         default: begin
            // spare codes: no effect, status ok
         end
      endcase
      // End words read as zero once the deque is empty.
      if (mirror_count != 0) begin
         outcome.front_data = mirror_words[mirror_front];
         outcome.back_data  = mirror_words[tail_index()];
      end
      outcome.count = COUNT_W'(mirror_count);
      return outcome;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic req_type make_request(input logic [OP_W-1:0]          op,
                                            input logic signed [DATA_W-1:0] word);
      req_type item;
      item.op        = op;
      item.push_data = word;
      return item;
   endfunction

   // Mostly random words, with the extremes and zero mixed in.
   function automatic logic signed [DATA_W-1:0] pick_word();
      case ($urandom_range(0, 15))
         0:       return 32'sh7FFFFFFF;
         1:       return 32'sh80000000;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // Offer one request and hold it until accepted. Called right after a rising
   // edge; returns right after the edge that accepted the request, with valid
   // still high so the next call can stream without a bubble.
   task automatic send_request(input req_type item);
      int unsigned gap;
      gap = 0;
      if (sender_idles && $urandom_range(0, 99) < 35) begin
         gap = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      // Outputs of the block update after the edge, so this sees the value
      // that was present at the edge itself.
      do @(posedge clock); while (!req_ready);
      expected_rsps.push_back(apply_deque_op(item));
   endtask

   // Lower valid and wait until every predicted response has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsps.size() != 0);
   endtask

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string field, input longint got, input longint want);
      $display("%0d ns: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
      error_count++;
   endtask

   // rsp_ready: random stalls, mostly short, a few long, plus a long hold-off
   // on request from a test task. The hold length is counted here.
   always @(posedge clock) begin : drive_rsp_ready
      int unsigned hold_left;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else if (holdoff_request != 0) begin
         hold_left = holdoff_request - 1;
         holdoff_request = 0;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (receiver_idles && $urandom_range(0, 99) < 20) begin
         hold_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                  : $urandom_range(10, 40);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare every accepted response with the oldest prediction.
   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("response with no request pending", 1, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.popped_data !== want.popped_data) begin
               report_mismatch("popped_data", rsp_data.popped_data, want.popped_data);
            end
            if (rsp_data.status !== want.status) begin
               report_mismatch("status", rsp_data.status, want.status);
            end
            if (rsp_data.front_data !== want.front_data) begin
               report_mismatch("front_data", rsp_data.front_data, want.front_data);
            end
            if (rsp_data.back_data !== want.back_data) begin
               report_mismatch("back_data", rsp_data.back_data, want.back_data);
            end
            if (rsp_data.count !== want.count) begin
               report_mismatch("count", rsp_data.count, want.count);
            end
         end
      end
   end

   // Hang guard.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Empty-deque requests, spare codes, extreme words, a fill to full and
   // pushes that must be refused.
   task automatic test_directed_corners();
      send_request(make_request(OP_POP_FRONT, pick_word()));   // empty pop
      send_request(make_request(OP_POP_BACK, pick_word()));
      send_request(make_request(OP_PEEK, pick_word()));        // empty peek
      send_request(make_request(OP_SPARE_7, pick_word()));     // no-op while empty
      send_request(make_request(OP_PUSH_BACK, 32'sh7FFFFFFF));
      send_request(make_request(OP_PUSH_FRONT, 32'sh80000000));
      send_request(make_request(OP_PEEK, pick_word()));
      send_request(make_request(OP_SPARE_5, pick_word()));     // no-op with data
      send_request(make_request(OP_POP_BACK, pick_word()));
      send_request(make_request(OP_POP_FRONT, pick_word()));   // back to empty
      // Fill from both ends so the front pointer wraps below slot zero.
      for (int i = 0; i < DEPTH; i++) begin
         send_request(make_request((i % 2 != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                                   (i % 4 == 0) ? -32'sd1 : pick_word()));
      end
      send_request(make_request(OP_PUSH_FRONT, pick_word()));  // full, refused
      send_request(make_request(OP_PUSH_BACK, pick_word()));
      send_request(make_request(OP_SPARE_6, pick_word()));     // no-op while full
   endtask

   // Random ops in phases that lean toward pushing or popping, so the deque
   // swings between full and empty many times.
   task automatic test_random_traffic(input int unsigned n_requests);
      int unsigned     push_share;
      int unsigned     roll;
      logic [OP_W-1:0] op;
      push_share = 50;
      for (int unsigned k = 0; k < n_requests; k++) begin
         if (k % 48 == 0) begin
            case ($urandom_range(0, 2))
               0:       push_share = 85;
               1:       push_share = 15;
               default: push_share = 50;
            endcase
         end
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            op = OP_SPARE_5 + OP_W'($urandom_range(0, 2));
         end else if (roll < 10) begin
            op = OP_PEEK;
         end else if ($urandom_range(0, 99) < push_share) begin
            op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
         end else begin
            op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
         end
         send_request(make_request(op, pick_word()));
      end
   endtask

   // Receiver holds off for a long stretch while the sender streams with no
   // gaps: the response register and the request in work fill up and
   // req_ready must drop until the receiver comes back.
   task automatic test_output_holdoff();
      sender_idles    = 1'b0;
      holdoff_request = HOLDOFF_CYCLES;
      test_random_traffic(60);
      sender_idles    = 1'b1;
   endtask

   // Sender pauses until nothing is outstanding, then both sides run flat out.
   task automatic test_drain_then_stream();
      wait_for_drain();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      test_random_traffic(160);
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_random_traffic(RANDOM_REQUESTS);
      test_output_holdoff();
      test_drain_then_stream();

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
